/* src/pdfc_pkg.sv */
// Shared constants and types for the PWM duty/frequency capture block.
// No dependencies; used by pdfc_edge_seq, the top level and the testbench.
`timescale 1ns / 1ps

package pdfc_pkg;

	// Default width of the capture counter
	localparam int COUNTER_BITS_DEF = 16;

	// Fixed field widths
	localparam int TIME_W      = 16;
	localparam int RATE_W      = 28;
	localparam int PERIOD_W    = 16;
	localparam int DUTY_W      = 7;
	localparam int CAP_EXT_W   = 32;
	localparam int OUT_DATA_W  = 56;

	// Reset tick rate and duty ceiling
	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000000);
	localparam logic [DUTY_W-1:0] DUTY_FULL  = DUTY_W'(100);

	// Edge sequence: first rise, fall, second rise
	typedef enum logic [2:0] {
		PH_RISE = 3'b001,
		PH_FALL = 3'b010,
		PH_END  = 3'b100
	} phase_t;

	// Top level control
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_BUSY = 2'b10
	} ctl_state_t;

	// Measurement handoff from the edge sequencer
	typedef struct packed {
		logic start;  // one-cycle pulse, operands valid
		logic sat;    // high time >= period, duty pinned at 100
		logic bad;    // zero period
	} meas_ctl_t;

endpackage

/* src/pdfc_serial_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on nothing; instantiated by pwm_duty_frequency_capture.
`timescale 1ns / 1ps

module pdfc_serial_div #(
	parameter int NUM_W = 28,
	parameter int DEN_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo,
	output logic             done
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;
	logic             ge;

	// One restoring step: bring down the next dividend bit, trial subtract
	assign shifted = {rem_q, num_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign ge      = (shifted >= {1'b0, den_q});

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: quotient bits shift into the dividend register
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
		end
	end

	assign quo  = num_q;
	assign done = done_q;

endmodule

/* src/pdfc_edge_seq.sv */
// Edge sequencer: tracks rise/fall/rise captures and forms period and high time.
// Depends on pdfc_pkg.
`timescale 1ns / 1ps

module pdfc_edge_seq #(
	parameter int COUNTER_BITS = pdfc_pkg::COUNTER_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic [pdfc_pkg::TIME_W-1:0]      capture_time,
	output logic                             last_edge,
	output pdfc_pkg::meas_ctl_t              meas,
	output logic [COUNTER_BITS-1:0]          period,
	output logic [COUNTER_BITS+pdfc_pkg::DUTY_W-1:0] high_x100
);

	localparam int HX_W = COUNTER_BITS + pdfc_pkg::DUTY_W;

	pdfc_pkg::phase_t          phase_q;
	logic [COUNTER_BITS-1:0]   first_q;
	logic [COUNTER_BITS-1:0]   fall_q;
	logic [COUNTER_BITS-1:0]   period_q;
	logic [HX_W-1:0]           hx_q;
	pdfc_pkg::meas_ctl_t       meas_q;

	logic [pdfc_pkg::CAP_EXT_W-1:0] cap_ext;
	logic [COUNTER_BITS-1:0]   t_cnt;
	logic [COUNTER_BITS-1:0]   period_d;
	logic [COUNTER_BITS-1:0]   high_d;
	logic [HX_W-1:0]           high_ext;
	logic [HX_W-1:0]           hx_d;

	// Capture value reduced to the counter width
	assign cap_ext  = pdfc_pkg::CAP_EXT_W'(capture_time);
	assign t_cnt    = cap_ext[COUNTER_BITS-1:0];

	// Wrapping differences
	assign period_d = t_cnt - first_q;
	assign high_d   = fall_q - first_q;

	// high * 100 as 64 + 32 + 4
	assign high_ext = HX_W'(high_d);
	assign hx_d     = (high_ext << 6) + (high_ext << 5) + (high_ext << 2);

	assign last_edge = (phase_q == pdfc_pkg::PH_END);

	// Phase tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pdfc_pkg::PH_RISE;
			first_q <= '0;
			fall_q  <= '0;
			meas_q  <= '0;
		end else begin
			meas_q.start <= accept && last_edge;
			if (accept) begin
				case (phase_q)
					pdfc_pkg::PH_FALL: begin
						fall_q  <= t_cnt;
						phase_q <= pdfc_pkg::PH_END;
					end
					pdfc_pkg::PH_END: begin
						meas_q.sat <= (high_d >= period_d);
						meas_q.bad <= (period_d == '0);
						phase_q    <= pdfc_pkg::PH_RISE;
					end
					default: begin
						first_q <= t_cnt;
						phase_q <= pdfc_pkg::PH_FALL;
					end
				endcase
			end
		end
	end

	// Measurement operands
	always_ff @(posedge clk) begin
		if (accept && last_edge) begin
			period_q <= period_d;
			hx_q     <= hx_d;
		end
	end

	assign meas      = meas_q;
	assign period    = period_q;
	assign high_x100 = hx_q;

endmodule

/* src/pwm_duty_frequency_capture.sv */
// Top level of the PWM duty/frequency capture block.
// Depends on pdfc_pkg, pdfc_edge_seq and pdfc_serial_div.
//
// Usage:
//  s_tdata[15:0] carries one capture timestamp per word; words must follow
//  the order rising edge, falling edge, rising edge. The first two words of
//  a sequence are accepted while idle and give no result. The third
//  word completes a measurement: two bit-serial dividers (tick rate over
//  period, and high time x 100 over period) run side by side, one quotient
//  bit per cycle, and the result word is loaded into the output register
//  that drives m_tdata/m_tuser once both are done; the longer divider
//  decides when. s_tready is low from the third word until the result has
//  been loaded into the output register.
//  The output register holds the result while m_tready is low; the next
//  two captures are still taken, and a following third capture waits
//  after its division until the held word is taken.
//  cfg_wen/cfg_wdata write the tick rate; write it only while idle.
//  Reset restarts the edge sequence and sets the tick rate to 1000000.
`timescale 1ns / 1ps

module pwm_duty_frequency_capture #(
	parameter int COUNTER_BITS = pdfc_pkg::COUNTER_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// capture_time [15:0]
	input  logic [pdfc_pkg::TIME_W-1:0]         s_tdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// period_ticks [15:0], frequency_hz [43:16], duty_percent [50:44], zero pad
	output logic [pdfc_pkg::OUT_DATA_W-1:0]     m_tdata,
	// bad_period [0]
	output logic                                m_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic                                cfg_wen,
	input  logic [pdfc_pkg::RATE_W-1:0]         cfg_wdata
);

	localparam int HX_W = COUNTER_BITS + pdfc_pkg::DUTY_W;

	pdfc_pkg::ctl_state_t               state_q;
	logic [pdfc_pkg::RATE_W-1:0]        rate_q;
	logic                               fdone_q;
	logic                               ddone_q;
	logic                               sat_q;
	logic                               bad_q;
	logic                               m_tvalid_q;
	logic [pdfc_pkg::PERIOD_W-1:0]      period_q;
	logic [pdfc_pkg::RATE_W-1:0]        freq_q;
	logic [pdfc_pkg::DUTY_W-1:0]        duty_q;
	logic                               bad_out_q;

	logic                               accept;
	logic                               last_edge;
	pdfc_pkg::meas_ctl_t                meas;
	logic [COUNTER_BITS-1:0]            period;
	logic [HX_W-1:0]                    high_x100;
	logic [pdfc_pkg::RATE_W-1:0]        freq_quo;
	logic [HX_W-1:0]                    duty_quo;
	logic                               f_done;
	logic                               d_done;
	logic                               all_done;
	logic                               out_free;
	logic                               load_out;
	logic [pdfc_pkg::CAP_EXT_W-1:0]     period_ext;
	logic [pdfc_pkg::DUTY_W-1:0]        duty_d;

	assign s_tready = (state_q == pdfc_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Edge sequencing and operand formation
	pdfc_edge_seq #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.capture_time (s_tdata),
		.last_edge    (last_edge),
		.meas         (meas),
		.period       (period),
		.high_x100    (high_x100)
	);

	// Frequency: tick rate / period
	pdfc_serial_div #(
		.NUM_W(pdfc_pkg::RATE_W),
		.DEN_W(COUNTER_BITS)
	) u_fdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (meas.start),
		.num    (rate_q),
		.den    (period),
		.quo    (freq_quo),
		.done   (f_done)
	);

	// Duty: high * 100 / period
	pdfc_serial_div #(
		.NUM_W(HX_W),
		.DEN_W(COUNTER_BITS)
	) u_ddiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (meas.start),
		.num    (high_x100),
		.den    (period),
		.quo    (duty_quo),
		.done   (d_done)
	);

	assign all_done = (fdone_q || f_done) && (ddone_q || d_done);
	assign out_free = !m_tvalid_q || m_tready;
	assign load_out = (state_q == pdfc_pkg::ST_BUSY) && all_done && out_free;

	// Tick rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= pdfc_pkg::RATE_RESET;
		end else if (cfg_wen) begin
			rate_q <= cfg_wdata;
		end
	end

	// Control: idle until a third capture, busy until result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pdfc_pkg::ST_IDLE;
			fdone_q    <= 1'b0;
			ddone_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				pdfc_pkg::ST_IDLE: begin
					fdone_q <= 1'b0;
					ddone_q <= 1'b0;
					if (accept && last_edge) begin
						state_q <= pdfc_pkg::ST_BUSY;
					end
				end
				pdfc_pkg::ST_BUSY: begin
					if (f_done) fdone_q <= 1'b1;
					if (d_done) ddone_q <= 1'b1;
					if (load_out) begin
						state_q <= pdfc_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= pdfc_pkg::ST_IDLE;
				end
			endcase
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Flags that travel with the measurement
	always_ff @(posedge clk) begin
		if (meas.start) begin
			sat_q <= meas.sat;
			bad_q <= meas.bad;
		end
	end

	// Result shaping
	assign period_ext = pdfc_pkg::CAP_EXT_W'(period);
	assign duty_d     = bad_q ? '0 :
	                    sat_q ? pdfc_pkg::DUTY_FULL : duty_quo[pdfc_pkg::DUTY_W-1:0];

	// Output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			period_q  <= period_ext[pdfc_pkg::PERIOD_W-1:0];
			freq_q    <= bad_q ? '0 : freq_quo;
			duty_q    <= duty_d;
			bad_out_q <= bad_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = bad_out_q;
	assign m_tdata  = pdfc_pkg::OUT_DATA_W'({duty_q, freq_q, period_q});

endmodule

/* dv/pwm_duty_frequency_capture_tb.sv */
// Self-checking testbench for pwm_duty_frequency_capture: streams capture timestamps,
// predicts period, frequency and duty per completed edge sequence and checks every word.
// Depends on pdfc_pkg and the block's RTL in src/.
`timescale 1ns / 1ps

module pwm_duty_frequency_capture_tb;
	import pdfc_pkg::*;

	localparam int CYCLE_LIMIT  = 2000000;
	localparam int SETTLE_TICKS = 40;     // extra wait after the last pending result
	localparam int HOLD_TICKS   = 400;    // long receiver hold-off
	localparam int RAND_CHUNK   = 200;

	// One predicted measurement
	typedef struct packed {
		logic [PERIOD_W-1:0] period;
		logic [RATE_W-1:0]   freq;
		logic [DUTY_W-1:0]   duty;
		logic                bad;
	} meas_t;

	// Tracks the edge sequence and holds the measurements still to come out
	class capture_scoreboard;
		logic [RATE_W-1:0] tick_rate;
		phase_t            phase;
		logic [TIME_W-1:0] rise_time;
		logic [TIME_W-1:0] fall_time;
		meas_t             meas_q[$];
		int                mismatches;
		int                captures;
		int                results;
		int                bad_seen;
		int                full_seen;

		function new();
			tick_rate = RATE_RESET;
			phase = PH_RISE;
			rise_time = '0;
			fall_time = '0;
			mismatches = 0;
			captures = 0;
			results = 0;
			bad_seen = 0;
			full_seen = 0;
		endfunction

		function void set_rate(logic [RATE_W-1:0] v);
			tick_rate = v;
		endfunction

		function int pending();
			return meas_q.size();
		endfunction

		// Advance the edge sequence on an accepted capture word
		function void note_capture(logic [TIME_W-1:0] t);
			meas_t             m;
			logic [TIME_W-1:0] period;
			logic [TIME_W-1:0] high;
			int unsigned       duty;
			captures++;
			case (phase)
				PH_FALL: begin
					fall_time = t;
					phase = PH_END;
				end
				PH_END: begin
					period = t - rise_time;
					high = fall_time - rise_time;
					m = '0;
					if (period == '0) begin
						m.bad = 1'b1;
					end else begin
						m.period = period;
						m.freq = tick_rate / period;
						duty = (32'(high) * 32'd100) / 32'(period);
						m.duty = (duty > 100) ? DUTY_FULL : DUTY_W'(duty);
					end
					meas_q.push_back(m);
					phase = PH_RISE;
				end
				default: begin
					rise_time = t;
					phase = PH_FALL;
				end
			endcase
		endfunction

		// Compare a result word with the oldest measurement
		function void check_result(logic [OUT_DATA_W-1:0] d, logic u);
			meas_t               m;
			logic [PERIOD_W-1:0] p;
			logic [RATE_W-1:0]   f;
			logic [DUTY_W-1:0]   dt;
			p = d[PERIOD_W-1:0];
			f = d[PERIOD_W +: RATE_W];
			dt = d[PERIOD_W+RATE_W +: DUTY_W];
			results++;
			if (meas_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result word with none pending: period=%0d freq=%0d duty=%0d bad=%0b",
						$realtime, p, f, dt, u);
				return;
			end
			m = meas_q.pop_front();
			if (m.bad)
				bad_seen++;
			if (m.duty == DUTY_FULL)
				full_seen++;
			if (m.period !== p || m.freq !== f || m.duty !== dt || m.bad !== u) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch exp period=%0d freq=%0d duty=%0d bad=%0b, got period=%0d freq=%0d duty=%0d bad=%0b",
						$realtime, m.period, m.freq, m.duty, m.bad, p, f, dt, u);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic [TIME_W-1:0]     s_tdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic                  cfg_wen = 1'b0;
	logic [RATE_W-1:0]     cfg_wdata = '0;

	capture_scoreboard sb = new();
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	bit rx_hold_req = 1'b0;
	int rate_settings = 1;
	int cycle_count = 0;

	pwm_duty_frequency_capture dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Sender idle length: mostly none, some short, a few long
	function int tx_gap();
		int r;
		if (tx_steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 80);
	endfunction

	// Offer one capture word and wait for it to be taken
	task automatic send_capture(input logic [TIME_W-1:0] t);
		int gap;
		s_tdata <= t;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_capture(t);
		gap = tx_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Rise, fall, rise
	task automatic send_edges(input logic [TIME_W-1:0] r1, input logic [TIME_W-1:0] f,
			input logic [TIME_W-1:0] r2);
		send_capture(r1);
		send_capture(f);
		send_capture(r2);
	endtask

	// Stop offering and wait out every pending measurement
	task automatic pause_sender();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_tick_rate(input logic [RATE_W-1:0] v);
		pause_sender();
		cfg_wdata <= v;
		cfg_wen <= 1'b1;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.set_rate(v);
		rate_settings++;
	endtask

	// Mostly well-formed edge sequences, some stray words that shift the phase
	task automatic run_random(input int n);
		int                sent;
		logic [TIME_W-1:0] rise;
		logic [TIME_W-1:0] high;
		logic [TIME_W-1:0] period;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 19) == 0) begin
				send_capture(TIME_W'($urandom));
				sent++;
			end else begin
				rise = TIME_W'($urandom);
				case ($urandom_range(0, 9))
					0: period = TIME_W'($urandom_range(1, 16));
					1: period = '0;
					2: period = TIME_W'(16'hFFFF - $urandom_range(0, 255));
					default: period = TIME_W'($urandom);
				endcase
				if ($urandom_range(0, 9) == 0)
					high = TIME_W'($urandom);
				else
					high = TIME_W'($urandom_range(0, period));
				send_edges(rise, rise + high, rise + period);
				sent += 3;
			end
		end
	endtask

	// Receiver: check each taken word, then pick the next ready level
	int rx_stall = 0;
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				rx_stall = HOLD_TICKS;
			end
			if (rx_stall > 0) begin
				rx_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!rx_steady) begin
					case ($urandom_range(0, 99)) inside
						[0:9]:   rx_stall = $urandom_range(1, 3);
						[10:12]: rx_stall = $urandom_range(20, 100);
						default: rx_stall = 0;
					endcase
				end
			end
		end
	end

	// Run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// Main sequence
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cases at the reset tick rate
		send_edges(16'h0000, 16'h0000, 16'h0000);  // zero period
		send_edges(16'h0000, 16'hFFFF, 16'hFFFF);  // full-scale period, high equal to period
		send_edges(16'hFFFF, 16'h0000, 16'h0001);  // wrap past counter end
		send_edges(16'd100, 16'd200, 16'd150);     // high longer than period, duty pinned
		send_edges(16'h0000, 16'h0001, 16'h0001);  // one-tick period, frequency is the rate
		send_edges(16'h0001, 16'h8000, 16'h0000);  // period 0xFFFF
		send_edges(16'd5, 16'd5, 16'd40005);       // zero high time
		pause_sender();

		// Fastest rate; receiver holds off while words keep coming
		write_tick_rate(RATE_W'(170000000));
		rx_hold_req = 1'b1;
		tx_steady = 1'b1;
		run_random(40);
		tx_steady = 1'b0;
		pause_sender();
		run_random(RAND_CHUNK);

		write_tick_rate(RATE_W'(1));
		run_random(RAND_CHUNK);

		// Stretch with no idling on either side
		write_tick_rate(RATE_W'($urandom_range(1, 170000000)));
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		run_random(RAND_CHUNK);
		tx_steady = 1'b0;
		rx_steady = 1'b0;

		write_tick_rate(RATE_RESET);
		run_random(RAND_CHUNK);

		write_tick_rate(RATE_W'($urandom_range(1, 4096)));
		run_random(RAND_CHUNK);

		write_tick_rate(RATE_W'($urandom_range(1, 170000000)));
		run_random(RAND_CHUNK);

		pause_sender();
		$display("Covered %0d capture words, %0d result words (%0d zero period, %0d full duty)",
			sb.captures, sb.results, sb.bad_seen, sb.full_seen);
		$display("over %0d tick rate settings, %0d mismatches, %0d measurements left",
			rate_settings, sb.mismatches, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
